// ===== hw/rtl/prd_pkg.sv =====
`timescale 1ns / 1ps

package prd_pkg;

  // Field widths of the channels.
  localparam int XW = 32;
  localparam int AW = 26;

  // Number of micro-rotation stages; the arctangent table has 32 entries.
  localparam int ITERATIONS = 24;
  localparam int NITER = (ITERATIONS > 32) ? 32 : ITERATIONS;

  // Extra fraction bits carried by the coordinates through the rotator.
  localparam int GUARD = 16;
  // Datapath width for coordinates in Q18.32, two integer bits of headroom for the CORDIC gain.
  localparam int CW = 50;
  // Residual angle in degrees with 24 fraction bits.
  localparam int ZW = 32;
  // Reduced angle in Q9.16 degrees, (-180, 180].
  localparam int RW = 25;
  // Width of a coordinate times the gain correction.
  localparam int PW = 63;

  localparam logic signed [AW:0]   DEG_FULL    = 27'sd23592960;
  localparam logic signed [AW:0]   DEG_HALF    = 27'sd11796480;
  localparam logic signed [RW-1:0] DEG_QUARTER = 25'sd5898240;

  // Inverse CORDIC gain, Q1.30.
  localparam logic signed [30:0] GAIN_Q30 = 31'sd652032874;

  typedef struct packed {
    logic                 zero;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } prd_vec_t;

  // atan(2^-i) in degrees with 24 fraction bits.
  function automatic logic signed [ZW-1:0] prd_atan(input logic [4:0] idx);
    logic signed [ZW-1:0] val;
    unique case (idx)
      5'd0:  val = 32'sd754974720;
      5'd1:  val = 32'sd445687602;
      5'd2:  val = 32'sd235489088;
      5'd3:  val = 32'sd119537938;
      5'd4:  val = 32'sd60000934;
      5'd5:  val = 32'sd30029717;
      5'd6:  val = 32'sd15018523;
      5'd7:  val = 32'sd7509720;
      5'd8:  val = 32'sd3754917;
      5'd9:  val = 32'sd1877466;
      5'd10: val = 32'sd938734;
      5'd11: val = 32'sd469367;
      5'd12: val = 32'sd234684;
      5'd13: val = 32'sd117342;
      5'd14: val = 32'sd58671;
      5'd15: val = 32'sd29335;
      5'd16: val = 32'sd14668;
      5'd17: val = 32'sd7334;
      5'd18: val = 32'sd3667;
      5'd19: val = 32'sd1833;
      5'd20: val = 32'sd917;
      5'd21: val = 32'sd458;
      5'd22: val = 32'sd229;
      5'd23: val = 32'sd115;
      5'd24: val = 32'sd57;
      5'd25: val = 32'sd29;
      5'd26: val = 32'sd14;
      5'd27: val = 32'sd7;
      5'd28: val = 32'sd4;
      5'd29: val = 32'sd2;
      5'd30: val = 32'sd1;
      5'd31: val = 32'sd0;
    endcase
    return val;
  endfunction

endpackage

// ===== hw/rtl/prd_ifs.sv =====
`timescale 1ns / 1ps

interface prd_in_if import prd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [XW-1:0] x_in;
  logic signed [XW-1:0] y_in;
  logic signed [AW-1:0] angle_deg;

  modport source (output valid, output x_in, output y_in, output angle_deg, input ready);
  modport sink (input valid, input x_in, input y_in, input angle_deg, output ready);
endinterface

interface prd_out_if import prd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [XW-1:0] x_out;
  logic signed [XW-1:0] y_out;
  logic                 saturated;

  modport source (output valid, output x_out, output y_out, output saturated, input ready);
  modport sink (input valid, input x_out, input y_out, input saturated, output ready);
endinterface

// ===== hw/rtl/point_rotate_degrees.sv =====
`timescale 1ns / 1ps

// Rotates a Q16.16 point counter-clockwise about the origin by a Q10.16 angle in
// degrees, using a CORDIC rotator. One item is accepted every cycle unless an
// output stall has filled every stage; each item passes through 4 + ITERATIONS
// register stages (28 with 24 micro-rotations): three front stages reduce the
// angle modulo 360, apply the gain correction and any quarter turn, one stage per
// micro-rotation follows, and a last stage rounds and saturates. A stall at the
// output backs up only as far as the first empty stage, so the input keeps
// accepting while bubbles remain. A zero angle after reduction returns the point
// unchanged.
module point_rotate_degrees import prd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  prd_in_if.sink    in_ch,
  prd_out_if.source out_ch
);

  logic     fr_valid;
  prd_vec_t fr_data;
  logic     fr_ready;
  logic     rot_valid;
  prd_vec_t rot_data;
  logic     rot_ready;

  prd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_valid (fr_valid),
    .out_data  (fr_data),
    .out_ready (fr_ready)
  );

  prd_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_data   (fr_data),
    .in_ready  (fr_ready),
    .out_valid (rot_valid),
    .out_data  (rot_data),
    .out_ready (rot_ready)
  );

  prd_finish u_finish (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (rot_valid),
    .in_data  (rot_data),
    .in_ready (rot_ready),
    .out_ch   (out_ch)
  );

`ifndef SYNTHESIS
  // A consumer that is ready lets every stage move, so the input must be open.
  a_ready_through : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.ready |-> in_ch.ready)
    else $error("input not ready although the output is being taken");

  // With the output register empty nothing can be blocked.
  a_empty_open : assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with an empty output register");

  // No result may appear straight out of reset.
  a_reset_clear : assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_ch.valid)
    else $error("result offered in the first cycle after reset");
`endif

endmodule

// ===== hw/rtl/prd_front.sv =====
`timescale 1ns / 1ps

module prd_front import prd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  prd_in_if.sink   in_ch,
  output logic     out_valid,
  output prd_vec_t out_data,
  input  logic     out_ready
);

  // Stage 1: angle reduction.
  logic                 s1_valid_r;
  logic signed [XW-1:0] s1_x_r;
  logic signed [XW-1:0] s1_y_r;
  logic signed [RW-1:0] s1_ang_r;
  logic                 s1_zero_r;
  logic signed [AW:0]   ang_ext;
  logic signed [AW:0]   ang_red;
  logic signed [RW-1:0] s1_ang_nxt;
  logic                 s1_zero_nxt;

  // Stage 2: gain correction products.
  logic                 s2_valid_r;
  logic signed [XW-1:0] s2_x_r;
  logic signed [XW-1:0] s2_y_r;
  logic signed [PW-1:0] s2_prod_x_r;
  logic signed [PW-1:0] s2_prod_y_r;
  logic signed [RW-1:0] s2_ang_r;
  logic                 s2_zero_r;
  logic signed [PW-1:0] s2_prod_x_nxt;
  logic signed [PW-1:0] s2_prod_y_nxt;

  // Stage 3: rounding, quarter turn, residual angle.
  logic                       s3_valid_r;
  prd_vec_t                   s3_data_r;
  prd_vec_t                   s3_data_nxt;
  logic signed [PW-1:0]       rnd_x;
  logic signed [PW-1:0]       rnd_y;
  logic signed [CW-1:0]       gx;
  logic signed [CW-1:0]       gy;
  logic signed [XW+GUARD-1:0] pass_x;
  logic signed [XW+GUARD-1:0] pass_y;
  logic signed [RW-1:0]       ang_adj;
  logic signed [ZW-1:0]       ang_wide;

  logic s1_rdy;
  logic s2_rdy;
  logic s3_rdy;

  assign s3_rdy      = !s3_valid_r || out_ready;
  assign s2_rdy      = !s2_valid_r || s3_rdy;
  assign s1_rdy      = !s1_valid_r || s2_rdy;
  assign in_ch.ready = s1_rdy;

  // The input lies within [-512, 512) degrees, so one correction by 360 suffices.
  always_comb begin
    ang_ext = {in_ch.angle_deg[AW-1], in_ch.angle_deg};
    if (ang_ext > DEG_HALF) begin
      ang_red = ang_ext - DEG_FULL;
    end else if (ang_ext <= -DEG_HALF) begin
      ang_red = ang_ext + DEG_FULL;
    end else begin
      ang_red = ang_ext;
    end
    s1_ang_nxt  = ang_red[RW-1:0];
    s1_zero_nxt = (ang_red == '0);
  end

  assign s2_prod_x_nxt = PW'(s1_x_r) * PW'(GAIN_Q30);
  assign s2_prod_y_nxt = PW'(s1_y_r) * PW'(GAIN_Q30);

  always_comb begin
    rnd_x    = s2_prod_x_r + PW'(64'sd8192);
    rnd_y    = s2_prod_y_r + PW'(64'sd8192);
    gx       = CW'(rnd_x >>> 14);
    gy       = CW'(rnd_y >>> 14);
    pass_x   = {s2_x_r, {GUARD{1'b0}}};
    pass_y   = {s2_y_r, {GUARD{1'b0}}};
    ang_adj  = s2_ang_r;
    s3_data_nxt.zero = s2_zero_r;
    if (s2_zero_r) begin
      // A null rotation carries the point unchanged; the rotator holds it.
      s3_data_nxt.x = CW'(pass_x);
      s3_data_nxt.y = CW'(pass_y);
    end else if (s2_ang_r > DEG_QUARTER) begin
      s3_data_nxt.x = -gy;
      s3_data_nxt.y = gx;
      ang_adj       = s2_ang_r - DEG_QUARTER;
    end else if (s2_ang_r < -DEG_QUARTER) begin
      s3_data_nxt.x = gy;
      s3_data_nxt.y = -gx;
      ang_adj       = s2_ang_r + DEG_QUARTER;
    end else begin
      s3_data_nxt.x = gx;
      s3_data_nxt.y = gy;
    end
    ang_wide         = ZW'(ang_adj);
    s3_data_nxt.z    = ang_wide <<< 8;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s2_rdy) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s3_rdy) begin
        s3_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      s1_x_r    <= in_ch.x_in;
      s1_y_r    <= in_ch.y_in;
      s1_ang_r  <= s1_ang_nxt;
      s1_zero_r <= s1_zero_nxt;
    end
    if (s2_rdy) begin
      s2_x_r      <= s1_x_r;
      s2_y_r      <= s1_y_r;
      s2_prod_x_r <= s2_prod_x_nxt;
      s2_prod_y_r <= s2_prod_y_nxt;
      s2_ang_r    <= s1_ang_r;
      s2_zero_r   <= s1_zero_r;
    end
    if (s3_rdy) begin
      s3_data_r <= s3_data_nxt;
    end
  end

  assign out_valid = s3_valid_r;
  assign out_data  = s3_data_r;

endmodule

// ===== hw/rtl/prd_cordic.sv =====
`timescale 1ns / 1ps

module prd_cordic import prd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  prd_vec_t in_data,
  output logic     in_ready,
  output logic     out_valid,
  output prd_vec_t out_data,
  input  logic     out_ready
);

  logic [NITER-1:0] valid_r;
  prd_vec_t         data_r [NITER];
  logic [NITER:0]   rdy;

  assign rdy[NITER] = out_ready;
  assign in_ready   = rdy[0];
  assign out_valid  = valid_r[NITER-1];
  assign out_data   = data_r[NITER-1];

  for (genvar k = 0; k < NITER; k++) begin : g_stage
    localparam logic signed [ZW-1:0] ATAN_K = prd_atan(5'(k));

    logic                 src_valid;
    prd_vec_t             src;
    prd_vec_t             data_nxt;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [ZW-1:0] sz;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    if (k == 0) begin : g_first
      assign src_valid = in_valid;
      assign src       = in_data;
    end else begin : g_next
      assign src_valid = valid_r[k-1];
      assign src       = data_r[k-1];
    end

    assign rdy[k] = !valid_r[k] || rdy[k+1];

    always_comb begin
      sx = src.x;
      sy = src.y;
      sz = src.z;
      dx = sy >>> k;
      dy = sx >>> k;
      data_nxt.zero = src.zero;
      if (src.zero) begin
        data_nxt.x = sx;
        data_nxt.y = sy;
        data_nxt.z = sz;
      end else if (sz >= 0) begin
        data_nxt.x = sx - dx;
        data_nxt.y = sy + dy;
        data_nxt.z = sz - ATAN_K;
      end else begin
        data_nxt.x = sx + dx;
        data_nxt.y = sy - dy;
        data_nxt.z = sz + ATAN_K;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        valid_r[k] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        data_r[k] <= data_nxt;
      end
    end
  end

endmodule

// ===== hw/rtl/prd_finish.sv =====
`timescale 1ns / 1ps

module prd_finish import prd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  prd_vec_t in_data,
  output logic     in_ready,
  prd_out_if.source out_ch
);

  localparam logic signed [CW-1:0] OUT_MAX = CW'(64'sd2147483647);
  localparam logic signed [CW-1:0] OUT_MIN = -(CW'(64'sd2147483648));
  localparam logic signed [CW-1:0] HALF_LSB = CW'(32768);

  logic                 valid_r;
  logic signed [XW-1:0] x_r;
  logic signed [XW-1:0] y_r;
  logic                 sat_r;
  logic signed [XW-1:0] x_nxt;
  logic signed [XW-1:0] y_nxt;
  logic                 sat_nxt;
  logic signed [CW-1:0] qx;
  logic signed [CW-1:0] qy;
  logic                 clip_x;
  logic                 clip_y;

  assign in_ready = !valid_r || out_ch.ready;

  // Round half up to Q16.16, then clip to the 32-bit range.
  always_comb begin
    qx     = (in_data.x + HALF_LSB) >>> GUARD;
    qy     = (in_data.y + HALF_LSB) >>> GUARD;
    clip_x = (qx > OUT_MAX) || (qx < OUT_MIN);
    clip_y = (qy > OUT_MAX) || (qy < OUT_MIN);
    if (qx > OUT_MAX) begin
      x_nxt = XW'(OUT_MAX);
    end else if (qx < OUT_MIN) begin
      x_nxt = XW'(OUT_MIN);
    end else begin
      x_nxt = XW'(qx);
    end
    if (qy > OUT_MAX) begin
      y_nxt = XW'(OUT_MAX);
    end else if (qy < OUT_MIN) begin
      y_nxt = XW'(OUT_MIN);
    end else begin
      y_nxt = XW'(qy);
    end
    sat_nxt = clip_x || clip_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign out_ch.valid     = valid_r;
  assign out_ch.x_out     = x_r;
  assign out_ch.y_out     = y_r;
  assign out_ch.saturated = sat_r;

endmodule
